// File: hdl/line_follow_wheel_targets_macros.svh
// Assertion helpers for the line follower wheel target block.
// The assertions use the clock clk and the active-low reset rst_n of the module
// that expands them.
`ifndef LINE_FOLLOW_WHEEL_TARGETS_MACROS_SVH
`define LINE_FOLLOW_WHEEL_TARGETS_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LFWT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfwt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfwt next-cycle check failed");

`else

`define LFWT_ASSERT_SAME(lbl, ante, cons)
`define LFWT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/lfwt_pkg.sv
package lfwt_pkg;

  // Turn classes as reported on the result channel.
  typedef enum logic [2:0] {
    CLS_LOST        = 3'd0,
    CLS_STRAIGHT    = 3'd1,
    CLS_SMALL_LEFT  = 3'd2,
    CLS_SMALL_RIGHT = 3'd3,
    CLS_LARGE_LEFT  = 3'd4,
    CLS_LARGE_RIGHT = 3'd5
  } cls_t;

  // How the wheel targets of an item are formed.
  typedef enum logic [1:0] {
    ACT_ZERO       = 2'd0,
    ACT_FORM       = 2'd1,
    ACT_SPIN_RIGHT = 2'd2,
    ACT_SPIN_LEFT  = 2'd3
  } act_t;

  // Lost line modes.
  localparam logic [1:0] LOST_STOP   = 2'd0;
  localparam logic [1:0] LOST_SEARCH = 2'd1;
  localparam logic [1:0] LOST_HOLD   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_PCT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_PCT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BIAS    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BIAS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_SPEED = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_MODE    = 4'd7;

  localparam int IN_W  = 8;
  localparam int OUT_W = 64;

  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every dividend below 2**22, which covers 32768 * 127.
  localparam int PROD_W      = 22;
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W     = 23;
  localparam int QUOT_W      = 16;
  localparam int WIDE_W      = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_K = 23'd5368710;

  typedef struct packed {
    logic signed [14:0] base_speed;
    logic [6:0]         small_pct;
    logic [6:0]         large_pct;
    logic signed [14:0] left_bias;
    logic signed [14:0] right_bias;
    logic [13:0]        search_speed;
    logic               active_level;
    logic [1:0]         lost_mode;
  } cfg_t;

  // Classified item handed from the classifier to the target pipeline.
  typedef struct packed {
    logic [7:0]        raw;
    logic              seen;
    logic signed [2:0] err;
    cls_t              cls;
    act_t              act;
    cls_t              tcls;
  } item_t;

endpackage

// File: hdl/lfwt_classify.sv
module lfwt_classify
  import lfwt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] raw,
  input  logic       upd,
  input  logic       active_level,
  input  logic [1:0] lost_mode,
  output item_t      item
);

  logic signed [2:0] last_error_r;
  cls_t              last_turn_r;
  logic [3:0]        s;
  logic              seen;
  cls_t              cls;
  logic signed [2:0] err;

  // A sensor is active when its bit equals the configured level.
  assign s    = raw[3:0] ~^ {4{active_level}};
  assign seen = |s;

  always_comb begin
    if (!seen) begin
      cls = CLS_LOST;
      err = last_error_r;
    end else if (s[1] && s[2]) begin
      cls = CLS_STRAIGHT;
      err = 3'sd0;
    end else if (s[0] && !s[3]) begin
      cls = CLS_LARGE_LEFT;
      err = 3'sd2;
    end else if (s[3] && !s[0]) begin
      cls = CLS_LARGE_RIGHT;
      err = -3'sd2;
    end else if (s[1] && !s[2]) begin
      cls = CLS_SMALL_LEFT;
      err = 3'sd1;
    end else if (s[2] && !s[1]) begin
      cls = CLS_SMALL_RIGHT;
      err = -3'sd1;
    end else begin
      cls = CLS_STRAIGHT;
      err = 3'sd0;
    end
  end

  always_comb begin
    item.raw  = raw;
    item.seen = seen;
    item.err  = err;
    item.cls  = cls;
    item.tcls = cls;
    item.act  = ACT_ZERO;
    if (seen) begin
      item.act = ACT_FORM;
    end else begin
      case (lost_mode)
        LOST_SEARCH: begin
          if (last_error_r[2]) begin
            item.act = ACT_SPIN_RIGHT;
          end else if (last_error_r != 3'sd0) begin
            item.act = ACT_SPIN_LEFT;
          end
        end
        LOST_HOLD: begin
          item.act  = ACT_FORM;
          item.tcls = last_turn_r;
        end
        default: item.act = ACT_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= 3'sd0;
      last_turn_r  <= CLS_STRAIGHT;
    end else if (upd && seen) begin
      last_error_r <= err;
      last_turn_r  <= cls;
    end
  end

endmodule

// File: hdl/lfwt_targets.sv
module lfwt_targets
  import lfwt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  echo,
  output logic        detected,
  output logic [2:0]  err_o,
  output logic [2:0]  cls_o,
  output logic [15:0] left_o,
  output logic [15:0] right_o,
  output logic [16:0] corr_o
);

  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo     = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1: side sums, pick the inner wheel, multiply its magnitude by the percent.
  item_t              it1_r;
  logic signed [15:0] l_sum, r_sum, sel_sum;
  logic               scl_l, scl_r, neg;
  logic [15:0]        mag;
  logic [6:0]         pct;
  logic [22:0]        prod_full;

  logic signed [15:0] l_sum2_r, r_sum2_r, l_sum3_r, r_sum3_r;
  logic               scl_l2_r, scl_r2_r, neg2_r, scl_l3_r, scl_r3_r, neg3_r;
  logic [PROD_W-1:0]  prod2_r;
  item_t              it2_r, it3_r;
  logic [WIDE_W-1:0]  wide;
  logic [QUOT_W-1:0]  quot3_r;

  assign l_sum   = 16'(cfg.base_speed) + 16'(cfg.left_bias);
  assign r_sum   = 16'(cfg.base_speed) + 16'(cfg.right_bias);
  assign scl_l   = (it1_r.act == ACT_FORM) &&
                   (it1_r.tcls == CLS_SMALL_LEFT || it1_r.tcls == CLS_LARGE_LEFT);
  assign scl_r   = (it1_r.act == ACT_FORM) &&
                   (it1_r.tcls == CLS_SMALL_RIGHT || it1_r.tcls == CLS_LARGE_RIGHT);
  assign pct     = (it1_r.tcls == CLS_SMALL_LEFT || it1_r.tcls == CLS_SMALL_RIGHT) ?
                   cfg.small_pct : cfg.large_pct;
  assign sel_sum = scl_l ? l_sum : r_sum;
  assign neg     = sel_sum[15];
  assign mag     = neg ? 16'(-sel_sum) : 16'(sel_sum);
  assign prod_full = 23'(mag) * 23'(pct);

  // Stage 2: reciprocal multiply for the division by 100.
  assign wide = WIDE_W'(prod2_r) * WIDE_W'(RECIP_K);

  // Stage 3: signed, saturated inner wheel and final targets.
  logic signed [16:0] sq;
  logic signed [15:0] scaled, lt, rt;

  assign sq = neg3_r ? -$signed({1'b0, quot3_r}) : $signed({1'b0, quot3_r});

  always_comb begin
    if (sq > 17'sd32767) begin
      scaled = 16'sh7FFF;
    end else if (sq < -17'sd32768) begin
      scaled = 16'sh8000;
    end else begin
      scaled = sq[15:0];
    end
  end

  always_comb begin
    case (it3_r.act)
      ACT_FORM: begin
        lt = scl_l3_r ? scaled : l_sum3_r;
        rt = scl_r3_r ? scaled : r_sum3_r;
      end
      ACT_SPIN_RIGHT: begin
        lt = $signed(16'(cfg.search_speed));
        rt = -$signed(16'(cfg.search_speed));
      end
      ACT_SPIN_LEFT: begin
        lt = -$signed(16'(cfg.search_speed));
        rt = $signed(16'(cfg.search_speed));
      end
      default: begin
        lt = 16'sd0;
        rt = 16'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      it1_r <= item;
    end
    if (rdy2) begin
      it2_r    <= it1_r;
      l_sum2_r <= l_sum;
      r_sum2_r <= r_sum;
      scl_l2_r <= scl_l;
      scl_r2_r <= scl_r;
      neg2_r   <= neg;
      prod2_r  <= prod_full[PROD_W-1:0];
    end
    if (rdy3) begin
      it3_r    <= it2_r;
      l_sum3_r <= l_sum2_r;
      r_sum3_r <= r_sum2_r;
      scl_l3_r <= scl_l2_r;
      scl_r3_r <= scl_r2_r;
      neg3_r   <= neg2_r;
      quot3_r  <= wide[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    end
    if (rdyo) begin
      echo     <= it3_r.raw;
      detected <= it3_r.seen;
      err_o    <= it3_r.err;
      cls_o    <= it3_r.cls;
      left_o   <= lt;
      right_o  <= rt;
      corr_o   <= 17'(rt) - 17'(lt);
    end
  end

  assign out_valid = vo_r;

endmodule

// File: hdl/line_follow_wheel_targets.sv
// Line follower wheel targets.
// Each item on the in_ channel is one raw sample of four line sensors (bits 0 to 3,
// left to right). The block classifies it as lost, straight, small or large left,
// or small or large right, and returns one result item on the out_ channel with
// the echoed byte, the detect flag, the track error, the class and the left and
// right wheel speed targets together with their difference.
// Settings are written over the cfg_ channel, one register per item; cfg_ready is
// always high, and writes are expected only while no item is in flight.
// out_tvalid rises once an accepted item has reached the output register.
// One item is accepted per cycle while the output is not stalled:
// the input register, the percent product, the quotient of the reciprocal multiply
// that divides by 100 and the saturated output register each pass one item a cycle.
// When out_tready is low the pipeline fills its empty stages and then holds; in_tready
// drops only once every stage holds an item. The lost-line memory (last error and
// last turn) is updated at acceptance, so a stall never changes results.
// Reset clears the pipeline, restores all settings to their defaults and sets the
// last error to zero and the last turn to straight.
`include "line_follow_wheel_targets_macros.svh"

module line_follow_wheel_targets
  import lfwt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: sensor_raw[7:0]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // out_tdata: sensor_echo[7:0], line_detected[8], track_error[11:9],
  // turn_class[14:12], left_target[30:15], right_target[46:31], correction[63:47]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg_r;
  item_t       item;
  logic        in_acc;
  logic [7:0]  echo;
  logic        detected;
  logic [2:0]  err_o, cls_o;
  logic [15:0] left_o, right_o;
  logic [16:0] corr_o;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed   <= 15'sd0;
      cfg_r.small_pct    <= 7'd100;
      cfg_r.large_pct    <= 7'd100;
      cfg_r.left_bias    <= 15'sd0;
      cfg_r.right_bias   <= 15'sd0;
      cfg_r.search_speed <= 14'd0;
      cfg_r.active_level <= 1'b1;
      cfg_r.lost_mode    <= LOST_SEARCH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_SPEED:   cfg_r.base_speed   <= cfg_data[14:0];
        REG_SMALL_PCT:    cfg_r.small_pct    <= cfg_data[6:0];
        REG_LARGE_PCT:    cfg_r.large_pct    <= cfg_data[6:0];
        REG_LEFT_BIAS:    cfg_r.left_bias    <= cfg_data[14:0];
        REG_RIGHT_BIAS:   cfg_r.right_bias   <= cfg_data[14:0];
        REG_SEARCH_SPEED: cfg_r.search_speed <= cfg_data[13:0];
        REG_ACTIVE_LEVEL: cfg_r.active_level <= cfg_data[0];
        REG_LOST_MODE:    cfg_r.lost_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Classification and the lost-line memory act on the item as it is accepted.
  lfwt_classify u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .raw          (in_tdata[7:0]),
    .upd          (in_acc),
    .active_level (cfg_r.active_level),
    .lost_mode    (cfg_r.lost_mode),
    .item         (item)
  );

  lfwt_targets u_targets (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .echo      (echo),
    .detected  (detected),
    .err_o     (err_o),
    .cls_o     (cls_o),
    .left_o    (left_o),
    .right_o   (right_o),
    .corr_o    (corr_o)
  );

  assign out_tdata = {corr_o, right_o, left_o, cls_o, err_o, detected, echo};

  // A result without a detected line always reports the lost class.
  `LFWT_ASSERT_SAME(a_lost_class, out_tvalid && !detected, cls_o == CLS_LOST)

  // A detected line pairs each class with its own error value.
  `LFWT_ASSERT_SAME(a_class_error, out_tvalid && detected,
    (cls_o == CLS_STRAIGHT && err_o == 3'd0) || (cls_o == CLS_SMALL_LEFT && err_o == 3'd1) ||
    (cls_o == CLS_SMALL_RIGHT && err_o == 3'b111) ||
    (cls_o == CLS_LARGE_LEFT && err_o == 3'd2) || (cls_o == CLS_LARGE_RIGHT && err_o == 3'b110))

  // In stop mode a lost line drives both wheels to zero.
  `LFWT_ASSERT_SAME(a_stop_zero,
    out_tvalid && !detected && cfg_r.lost_mode == LOST_STOP,
    left_o == 16'd0 && right_o == 16'd0)

  // A result held under backpressure keeps its targets.
  `LFWT_ASSERT_NEXT(a_hold_targets, out_tvalid && !out_tready,
    $stable(left_o) && $stable(right_o) && $stable(corr_o))

endmodule
